@@ rtl/pcsc_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pcsc_pkg - shared types and arithmetic for the phase-change stretch unit
// Register codes, stage side-band struct, seed table, divide-by-three and
// the output scaling / rounding / saturation function.
// ============================================================================
package pcsc_pkg;

	localparam int NEWTON_STEPS_DEF = 3;
	localparam int OUT_FRAC_BITS    = 16;

	// APB register map, word index = paddr[3:2]
	typedef enum logic [1:0] {
		REG_EXPANSION = 2'd0,
		REG_CHANGE    = 2'd1,
		REG_INVERSE   = 2'd2
	} pcsc_reg_t;

	// reciprocal of three, ceil(2^35 / 3); exact floor for inputs below 2^34
	localparam logic [33:0] DIV3_MAGIC = 34'h2AAAAAAAB;

	// side-band data that travels with each request down the pipe
	typedef struct packed {
		logic signed [33:0] lin_v;
		logic signed [33:0] lin_c;
		logic               want_v;
		logic               want_d;
		logic               dom;
		logic [4:0]         k;
	} pcsc_side_t;

	function automatic logic [32:0] div3(input logic [33:0] n);
		logic [67:0] p;
		p = 68'(n) * 68'(DIV3_MAGIC);
		return p[67:35];
	endfunction

	// m^(-1/3) seed in Q12 at bucket midpoints (2i+9)/8
	function automatic logic [11:0] seed(input logic [4:0] idx);
		logic [11:0] s;
		case (idx)
			5'd0:    s = 12'd3938;
			5'd1:    s = 12'd3684;
			5'd2:    s = 12'd3484;
			5'd3:    s = 12'd3322;
			5'd4:    s = 12'd3186;
			5'd5:    s = 12'd3070;
			5'd6:    s = 12'd2969;
			5'd7:    s = 12'd2881;
			5'd8:    s = 12'd2802;
			5'd9:    s = 12'd2731;
			5'd10:   s = 12'd2667;
			5'd11:   s = 12'd2608;
			5'd12:   s = 12'd2555;
			5'd13:   s = 12'd2504;
			5'd14:   s = 12'd2458;
			5'd15:   s = 12'd2415;
			5'd16:   s = 12'd2375;
			5'd17:   s = 12'd2338;
			5'd18:   s = 12'd2303;
			5'd19:   s = 12'd2270;
			5'd20:   s = 12'd2239;
			5'd21:   s = 12'd2209;
			5'd22:   s = 12'd2181;
			5'd23:   s = 12'd2154;
			5'd24:   s = 12'd2129;
			5'd25:   s = 12'd2105;
			5'd26:   s = 12'd2081;
			default: s = 12'd2059;
		endcase
		return s;
	endfunction

	// scale magnitude by 2^s, round half up, saturate, apply sign
	function automatic logic [23:0] out_word(input logic [55:0] mag,
			input logic signed [8:0] s, input logic neg);
		logic [63:0] lim;
		logic [63:0] q;
		logic [87:0] wide;
		logic [63:0] rnd;
		logic [8:0]  r;
		lim  = neg ? 64'h80_0000 : 64'h7F_FFFF;
		q    = '0;
		wide = '0;
		rnd  = '0;
		r    = '0;
		if (s >= 0) begin
			if (mag == '0) begin
				q = '0;
			end else if (s >= 9'sd24) begin
				q = lim;
			end else begin
				wide = 88'(mag) << s[4:0];
				q = (wide > 88'(lim)) ? lim : wide[63:0];
			end
		end else begin
			r = 9'(-s);
			if (r >= 9'd63) begin
				q = '0;
			end else begin
				rnd = (64'(mag) + (64'd1 << (r - 9'd1))) >> r;
				q = (rnd > lim) ? lim : rnd;
			end
		end
		if (neg) q = 64'd0 - q;
		return q[23:0];
	endfunction

endpackage

@@ rtl/pcsc_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pcsc_if - request and result channels
// Valid/ready channels carrying one material point and one result.
// ============================================================================
interface pcsc_req_if;
	logic        valid;
	logic        ready;
	logic [15:0] fluid_frac;
	logic [15:0] phase_frac;
	logic        want_value;
	logic        want_derivs;

	modport source (output valid, fluid_frac, phase_frac, want_value, want_derivs,
		input ready);
	modport sink (input valid, fluid_frac, phase_frac, want_value, want_derivs,
		output ready);
endinterface

interface pcsc_res_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] stretch_diag;
	logic signed [23:0] deriv_fluid;
	logic signed [23:0] deriv_phase;
	logic               domain_error;

	modport source (output valid, stretch_diag, deriv_fluid, deriv_phase, domain_error,
		input ready);
	modport sink (input valid, stretch_diag, deriv_fluid, deriv_phase, domain_error,
		output ready);
endinterface

@@ rtl/pcsc_newton_step.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pcsc_newton_step - one pipelined Newton iteration for m^(-1/3)
// y' = floor(floor(y*(4 - m*y^3))/3), Q2.30, five register stages.
// ============================================================================
module pcsc_newton_step
	import pcsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        vld_i,
	input  logic [31:0] y_i,
	input  logic [32:0] mm_i,
	input  pcsc_side_t  side_i,
	output logic        vld_o,
	output logic [31:0] y_o,
	output logic [32:0] mm_o,
	output pcsc_side_t  side_o
);

	localparam logic [32:0] FOUR = 33'h1_0000_0000;

	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [31:0] y_s1, y_s2, y_s3, y_s5;
	logic [32:0] mm_s1, mm_s2, mm_s3, mm_s4, mm_s5;
	pcsc_side_t  side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [31:0] sq_s1, cu_s2;
	logic [34:0] ty_s3;
	logic [33:0] p_s4;

	logic [63:0] sq_full, cu_full;
	logic [64:0] ty_full, p_full;
	logic [32:0] df;

	assign sq_full = 64'(y_i) * 64'(y_i);
	assign cu_full = 64'(sq_s1) * 64'(y_s1);
	assign ty_full = 65'(mm_s2) * 65'(cu_s2);
	assign df      = (ty_s3 < 35'(FOUR)) ? 33'(35'(FOUR) - ty_s3) : 33'd0;
	assign p_full  = 65'(y_s3) * 65'(df);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s1    <= y_i;
			mm_s1   <= mm_i;
			side_s1 <= side_i;
			sq_s1   <= sq_full[61:30];

			y_s2    <= y_s1;
			mm_s2   <= mm_s1;
			side_s2 <= side_s1;
			cu_s2   <= cu_full[61:30];

			y_s3    <= y_s2;
			mm_s3   <= mm_s2;
			side_s3 <= side_s2;
			ty_s3   <= ty_full[64:30];

			mm_s4   <= mm_s3;
			side_s4 <= side_s3;
			p_s4    <= p_full[63:30];

			y_s5    <= 32'(div3(p_s4));
			mm_s5   <= mm_s4;
			side_s5 <= side_s4;
		end
	end

	assign vld_o  = vld_s5;
	assign y_o    = y_s5;
	assign mm_o   = mm_s5;
	assign side_o = side_s5;

endmodule

@@ rtl/phase_change_stretch_cube_root_unit.sv @@
`timescale 1ns / 1ps
// ============================================================================
// phase_change_stretch_cube_root_unit - isotropic phase-change stretch
// t = 1 + alpha*c*v + (1-c)*v*dOmega, then t^(+-1/3) and its derivatives.
// ============================================================================
// Usage
//   req : one material point per request (fluid and phase fraction, Q1.15,
//         plus flags asking for the value and/or both derivatives).
//   res : one result per request, in order: stretch diagonal, derivatives
//         in v and c (signed Q7.16) and a domain flag for t <= 0.
//   APB : alpha, dOmega and inverse mode at byte addresses 0, 4 and 8;
//         write them only while the pipe is empty.
// Timing
//   Fully pipelined, one request per cycle while the output is not stalled.
//   Four stages build and normalise t, each Newton iteration is five
//   multiplier stages, six stages form powers, the derivative products
//   and the output rounding.
// Reset
//   Clears the APB registers to zero and empties the pipe; no warm-up pass.
// Stall
//   When a result waits and res.ready is low, the whole pipe holds: nothing
//   is dropped or repeated, and req.ready drops in the same cycle.
// ============================================================================
module phase_change_stretch_cube_root_unit
	import pcsc_pkg::*;
#(
	parameter int NEWTON_STEPS = NEWTON_STEPS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	pcsc_req_if.sink      req,
	pcsc_res_if.source    res
);

	// ---------------------------------------------------------------- config
	logic signed [15:0] expansion_q;
	logic signed [15:0] change_q;
	logic               inverse_q;
	logic               wr_en;
	pcsc_reg_t          reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = pcsc_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expansion_q <= '0;
			change_q    <= '0;
			inverse_q   <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_EXPANSION: expansion_q <= pwdata[15:0];
				REG_CHANGE:    change_q    <= pwdata[15:0];
				REG_INVERSE:   inverse_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_EXPANSION: prdata = {16'd0, expansion_q};
			REG_CHANGE:    prdata = {16'd0, change_q};
			REG_INVERSE:   prdata = {31'd0, inverse_q};
			default:       prdata = '0;
		endcase
	end

	// ------------------------------------------------------------ pipe control
	// Single advance enable: the pipe moves unless the output holds an
	// untaken result.
	logic adv;
	logic vld_s10;

	assign adv       = !vld_s10 || res.ready;
	assign req.ready = adv;

	// ------------------------------------------------------ S1: linear factors
	// L_v = alpha*c + (1-c)*dOmega, L_c = v*(alpha - dOmega), Q27
	logic signed [17:0] omc;
	logic signed [16:0] adm;
	logic signed [33:0] ac, od, lin_v, lin_c;

	assign omc   = 18'sd32768 - $signed({2'b0, req.phase_frac});
	assign adm   = 17'(expansion_q) - 17'(change_q);
	assign ac    = 34'(expansion_q) * 34'($signed({1'b0, req.phase_frac}));
	assign od    = 34'(omc) * 34'(change_q);
	assign lin_v = ac + od;
	assign lin_c = 34'($signed({1'b0, req.fluid_frac})) * 34'(adm);

	logic               vld_s1;
	logic [15:0]        v_s1;
	logic signed [33:0] lin_v_s1, lin_c_s1;
	logic               want_v_s1, want_d_s1;

	// --------------------------------------------------------- S2: form t, Q42
	logic signed [51:0] t_full;
	logic               vld_s2;
	logic signed [51:0] t_s2;
	pcsc_side_t         side_s2;

	assign t_full = (52'sd1 <<< 42) + 52'($signed({1'b0, v_s1})) * 52'(lin_v_s1);

	// ----------------------------------------- S3: domain check, shift count
	// k = fewest 3-bit shifts that lift t to at least 2^57
	logic        dom;
	logic [50:0] tp;
	logic [4:0]  k_sel;
	logic        vld_s3;
	logic [50:0] tp_s3;
	pcsc_side_t  side_s3;

	assign dom = (t_s2 <= 52'sd0);
	assign tp  = dom ? 51'd1 : t_s2[50:0];

	always_comb begin
		k_sel = 5'd19;
		for (int i = 18; i >= 0; i--) begin
			if (64'(tp) >= (64'd1 << (57 - 3 * i))) k_sel = 5'(i);
		end
	end

	// ------------------------------------------------ S4: normalise and seed
	logic [59:0] m_norm;
	logic [5:0]  sh3;
	logic [4:0]  seed_idx;
	logic        vld_s4;
	logic [31:0] y_s4;
	logic [32:0] mm_s4;
	pcsc_side_t  side_s4;

	assign sh3      = {side_s3.k, 1'b0} + 6'(side_s3.k);
	assign m_norm   = 60'(tp_s3) << sh3;
	assign seed_idx = m_norm[59:55] - 5'd4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s1      <= req.fluid_frac;
			lin_v_s1  <= lin_v;
			lin_c_s1  <= lin_c;
			want_v_s1 <= req.want_value;
			want_d_s1 <= req.want_derivs;

			t_s2           <= t_full;
			side_s2.lin_v  <= lin_v_s1;
			side_s2.lin_c  <= lin_c_s1;
			side_s2.want_v <= want_v_s1;
			side_s2.want_d <= want_d_s1;
			side_s2.dom    <= 1'b0;
			side_s2.k      <= '0;

			tp_s3          <= tp;
			side_s3.lin_v  <= side_s2.lin_v;
			side_s3.lin_c  <= side_s2.lin_c;
			side_s3.want_v <= side_s2.want_v;
			side_s3.want_d <= side_s2.want_d;
			side_s3.dom    <= dom;
			side_s3.k      <= k_sel;

			y_s4    <= {2'b0, seed(seed_idx), 18'd0};
			mm_s4   <= m_norm[59:27];
			side_s4 <= side_s3;
		end
	end

	// ------------------------------------------------------- Newton iterations
	logic        vld_n  [NEWTON_STEPS+1];
	logic [31:0] y_n    [NEWTON_STEPS+1];
	logic [32:0] mm_n   [NEWTON_STEPS+1];
	pcsc_side_t  side_n [NEWTON_STEPS+1];

	assign vld_n[0]  = vld_s4;
	assign y_n[0]    = y_s4;
	assign mm_n[0]   = mm_s4;
	assign side_n[0] = side_s4;

	for (genvar g = 0; g < NEWTON_STEPS; g++) begin : g_newton
		pcsc_newton_step u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.vld_i  (vld_n[g]),
			.y_i    (y_n[g]),
			.mm_i   (mm_n[g]),
			.side_i (side_n[g]),
			.vld_o  (vld_n[g+1]),
			.y_o    (y_n[g+1]),
			.mm_o   (mm_n[g+1]),
			.side_o (side_n[g+1])
		);
	end

	// ------------------------------------------------------------ S5: y^2
	logic [63:0] y2_full;
	logic        vld_s5;
	logic [31:0] y_s5, y2_s5;
	logic [32:0] mm_s5;
	pcsc_side_t  side_s5;

	assign y2_full = 64'(y_n[NEWTON_STEPS]) * 64'(y_n[NEWTON_STEPS]);

	// ---------------------------------------------------- S6: y^4, cube root
	logic [63:0] y4_full;
	logic [64:0] cr_full;
	logic        vld_s6;
	logic [31:0] y_s6, y2_s6, y4_s6;
	logic [34:0] cr_s6;
	pcsc_side_t  side_s6;

	assign y4_full = 64'(y2_s5) * 64'(y2_s5);
	assign cr_full = 65'(mm_s5) * 65'(y2_s5);

	// ------------------------------------ S7: mantissa pick, |L| / 3 quotients
	// x*|L|/3 is split as x*floor(|L|/3) + floor(x*(|L| mod 3)/3)
	logic [31:0] x_pick;
	logic [33:0] abs_v, abs_c;
	logic        vld_s7;
	logic [21:0] xd_s7;
	logic [33:0] abs_v_s7, abs_c_s7;
	logic [32:0] qv_s7, qc_s7;
	logic [34:0] valmag_s7;
	pcsc_side_t  side_s7;

	assign x_pick = inverse_q ? y4_s6 : y2_s6;
	assign abs_v  = side_s6.lin_v[33] ? 34'(-side_s6.lin_v) : 34'(side_s6.lin_v);
	assign abs_c  = side_s6.lin_c[33] ? 34'(-side_s6.lin_c) : 34'(side_s6.lin_c);

	// ----------------------------------------------- S8: remainder products
	logic [33:0] rv_full, rc_full;
	logic [54:0] xqv, xqc;
	logic [23:0] xrv, xrc;
	logic        vld_s8;
	logic [54:0] xqv_s8, xqc_s8;
	logic [23:0] xrv_s8, xrc_s8;
	logic [34:0] valmag_s8;
	pcsc_side_t  side_s8;

	assign rv_full = abs_v_s7 - 34'(qv_s7) * 34'd3;
	assign rc_full = abs_c_s7 - 34'(qc_s7) * 34'd3;
	assign xqv     = 55'(xd_s7) * 55'(qv_s7);
	assign xqc     = 55'(xd_s7) * 55'(qc_s7);
	assign xrv     = 24'(xd_s7) * 24'(rv_full[1:0]);
	assign xrc     = 24'(xd_s7) * 24'(rc_full[1:0]);

	// --------------------------------------------- S9: derivative magnitudes
	logic        vld_s9;
	logic [55:0] magv_s9, magc_s9;
	logic [34:0] valmag_s9;
	pcsc_side_t  side_s9;

	// ----------------------------------------- S10: scale, round, saturate
	logic signed [8:0] ke;
	logic signed [8:0] sh_val, sh_der;
	logic              negv, negc;
	logic              show_v, show_d;
	logic [23:0]       stretch_s10, dfl_s10, dph_s10;
	logic              dom_s10;

	assign ke     = 9'(side_s9.k) - 9'sd5;
	assign sh_val = inverse_q ? (ke + 9'(OUT_FRAC_BITS) - 9'sd30)
	                          : (9'(OUT_FRAC_BITS) - 9'sd30 - ke);
	assign sh_der = (inverse_q ? (ke <<< 2) : (ke <<< 1)) + 9'(OUT_FRAC_BITS) - 9'sd47;
	assign negv   = side_s9.lin_v[33] != inverse_q;
	assign negc   = side_s9.lin_c[33] != inverse_q;
	assign show_v = side_s9.want_v && !side_s9.dom;
	assign show_d = side_s9.want_d && !side_s9.dom;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (adv) begin
			vld_s5  <= vld_n[NEWTON_STEPS];
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s5    <= y_n[NEWTON_STEPS];
			y2_s5   <= y2_full[61:30];
			mm_s5   <= mm_n[NEWTON_STEPS];
			side_s5 <= side_n[NEWTON_STEPS];

			y_s6    <= y_s5;
			y2_s6   <= y2_s5;
			y4_s6   <= y4_full[61:30];
			cr_s6   <= cr_full[64:30];
			side_s6 <= side_s5;

			xd_s7     <= x_pick[31:10];
			abs_v_s7  <= abs_v;
			abs_c_s7  <= abs_c;
			qv_s7     <= div3(abs_v);
			qc_s7     <= div3(abs_c);
			valmag_s7 <= inverse_q ? 35'(y_s6) : cr_s6;
			side_s7   <= side_s6;

			xqv_s8    <= xqv;
			xqc_s8    <= xqc;
			xrv_s8    <= xrv;
			xrc_s8    <= xrc;
			valmag_s8 <= valmag_s7;
			side_s8   <= side_s7;

			magv_s9   <= 56'(xqv_s8) + 56'(div3(34'(xrv_s8)));
			magc_s9   <= 56'(xqc_s8) + 56'(div3(34'(xrc_s8)));
			valmag_s9 <= valmag_s8;
			side_s9   <= side_s8;

			stretch_s10 <= show_v ? out_word(56'(valmag_s9), sh_val, 1'b0) : 24'd0;
			dfl_s10     <= show_d ? out_word(magv_s9, sh_der, negv) : 24'd0;
			dph_s10     <= show_d ? out_word(magc_s9, sh_der, negc) : 24'd0;
			dom_s10     <= side_s9.dom;
		end
	end

	assign res.valid        = vld_s10;
	assign res.stretch_diag = stretch_s10;
	assign res.deriv_fluid  = dfl_s10;
	assign res.deriv_phase  = dph_s10;
	assign res.domain_error = dom_s10;

`ifndef NO_ASSERTIONS
	// a domain fault never carries a value
	a_dom_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.domain_error |->
			res.stretch_diag == 24'sd0 && res.deriv_fluid == 24'sd0 &&
			res.deriv_phase == 24'sd0)
		else $error("domain fault with non-zero result");

	// intake only stops for a held result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready == (!res.valid || res.ready))
		else $error("request ready out of step with result stall");

	// a held result stays in the output stage
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s10 && !res.ready |=> vld_s10 && $stable(stretch_s10) && $stable(dfl_s10))
		else $error("held result lost");
`endif

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - phase-change stretch cube-root unit
// Drives material points through the request channel and programs the
// coefficients over APB. Every accepted request is predicted in fixed point,
// with its own Newton iteration for t^(-1/3). Results are compared field by
// field, in order, under random idling and a long result hold-off.
// ----------------------------------------------------------------------------
module testbench;
	import pcsc_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 40;

	// seed for m^(-1/3), Q12, at bucket midpoints (2i+9)/8
	localparam int ROOT_SEED [28] = '{
		3938, 3684, 3484, 3322, 3186, 3070, 2969, 2881, 2802, 2731,
		2667, 2608, 2555, 2504, 2458, 2415, 2375, 2338, 2303, 2270,
		2239, 2209, 2181, 2154, 2129, 2105, 2081, 2059};

	typedef struct {
		logic [23:0] diag;
		logic [23:0] d_fluid;
		logic [23:0] d_phase;
		logic        dom;
	} stretch_res_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	pcsc_req_if req ();
	pcsc_res_if res ();

	phase_change_stretch_cube_root_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req.sink),
		.res     (res.source)
	);

	// shadow of the coefficient registers
	longint      alpha_q;
	longint      domega_q;
	logic        inverse_q;

	stretch_res_t pending_results [$];
	int          error_count;
	int          result_count;
	int          domain_count;
	int          request_count;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          hold_cycles;	// receiver hold-off, counted down by the sink
	longint      cycle_count;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// scale magnitude by 2^s, round half up, saturate, then sign
	function automatic logic [23:0] scale_q16(logic [63:0] mag, int s, logic neg);
		logic [63:0] lim;
		logic [63:0] q;
		int          r;
		lim = neg ? 64'h80_0000 : 64'h7F_FFFF;
		if (s >= 0) begin
			if (mag == 0) q = 0;
			else if (s >= 24 || mag > (lim >> s)) q = lim;
			else q = mag << s;
		end else begin
			r = -s;
			if (r >= 63) q = 0;
			else q = (mag + (64'd1 << (r - 1))) >> r;
			if (q > lim) q = lim;
		end
		if (neg) q = 64'd0 - q;
		return q[23:0];
	endfunction

	// (1/3) * root power * linear factor, scaled down to Q16
	function automatic logic [23:0] slope_q16(logic [63:0] pw, longint lin, int e,
			logic negate);
		logic [63:0] al;
		logic [63:0] mag;
		al  = (lin < 0) ? 64'(-lin) : 64'(lin);
		mag = ((pw >> 10) * al) / 3;
		return scale_q16(mag, e + OUT_FRAC_BITS - 47, (lin < 0) != negate);
	endfunction

	function automatic stretch_res_t predict_stretch(logic [15:0] v_in, logic [15:0] c_in,
			logic want_v, logic want_d);
		stretch_res_t o;
		longint       v;
		longint       c;
		longint       omc;
		longint       t;
		longint       lv;
		longint       lc;
		logic [63:0]  m;
		logic [63:0]  mm;
		logic [63:0]  y;
		logic [63:0]  sq;
		logic [63:0]  cu;
		logic [63:0]  ty;
		logic [63:0]  df;
		logic [63:0]  y2;
		logic [63:0]  y4;
		logic [63:0]  cr;
		logic [63:0]  idx;
		int           k;
		v   = longint'(v_in);
		c   = longint'(c_in);
		omc = 32768 - c;
		t   = (64'sd1 <<< 42) + alpha_q * c * v + omc * v * domega_q;
		o   = '{diag: '0, d_fluid: '0, d_phase: '0, dom: 1'b0};
		if (t <= 0) begin
			o.dom = 1'b1;
			return o;
		end
		m = 64'(t);
		k = 0;
		while (m < (64'd1 << 57)) begin
			m = m << 3;
			k++;
		end
		idx = (m >> 55) - 4;
		if (idx > 27) idx = 27;
		mm = m >> 27;
		y  = 64'(ROOT_SEED[idx]) << 18;
		for (int i = 0; i < NEWTON_STEPS_DEF; i++) begin
			sq = (y * y) >> 30;
			cu = (sq * y) >> 30;
			ty = (mm * cu) >> 30;
			df = (ty < (64'd4 << 30)) ? (64'd4 << 30) - ty : 64'd0;
			y  = ((y * df) >> 30) / 3;
		end
		y2 = (y * y) >> 30;
		y4 = (y2 * y2) >> 30;
		cr = (mm * y2) >> 30;
		if (want_v) begin
			if (inverse_q) o.diag = scale_q16(y, (k - 5) + OUT_FRAC_BITS - 30, 1'b0);
			else o.diag = scale_q16(cr, (5 - k) + OUT_FRAC_BITS - 30, 1'b0);
		end
		if (want_d) begin
			lv = alpha_q * c + omc * domega_q;
			lc = v * (alpha_q - domega_q);
			if (inverse_q) begin
				o.d_fluid = slope_q16(y4, lv, 4 * (k - 5), 1'b1);
				o.d_phase = slope_q16(y4, lc, 4 * (k - 5), 1'b1);
			end else begin
				o.d_fluid = slope_q16(y2, lv, 2 * (k - 5), 1'b0);
				o.d_phase = slope_q16(y2, lc, 2 * (k - 5), 1'b0);
			end
		end
		return o;
	endfunction

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("%0t timeout with %0d results outstanding", $time,
				pending_results.size());
			$display("testbench: done, errors");
			$finish;
		end
	end

	// result sink: checks each accepted result against the oldest prediction,
	// then picks ready for the next cycle
	initial begin : result_sink
		stretch_res_t e;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res.valid && res.ready) begin
				result_count++;
				if (res.domain_error) domain_count++;
				if (pending_results.size() == 0) begin
					$display("%0t unexpected result diag=%h", $time, res.stretch_diag);
					error_count++;
				end else begin
					e = pending_results.pop_front();
					if (res.stretch_diag !== e.diag || res.deriv_fluid !== e.d_fluid ||
							res.deriv_phase !== e.d_phase || res.domain_error !== e.dom) begin
						$display("%0t mismatch exp diag=%h dv=%h dc=%h dom=%b",
							$time, e.diag, e.d_fluid, e.d_phase, e.dom);
						$display("%0t          got diag=%h dv=%h dc=%h dom=%b",
							$time, res.stretch_diag, res.deriv_fluid, res.deriv_phase,
							res.domain_error);
						error_count++;
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// APB write: setup phase, access phase, then idle
	task automatic write_reg(pcsc_reg_t r, logic [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (r)
			REG_EXPANSION: alpha_q  = longint'($signed(value));
			REG_CHANGE:    domega_q = longint'($signed(value));
			default:       inverse_q = value[0];
		endcase
		@(posedge clk);
	endtask

	task automatic set_coefs(logic [15:0] a, logic [15:0] d, logic inv);
		write_reg(REG_EXPANSION, a);
		write_reg(REG_CHANGE, d);
		write_reg(REG_INVERSE, {15'd0, inv});
	endtask

	// offer one request, record its prediction once accepted
	task automatic send_point(logic [15:0] v, logic [15:0] c, logic wv, logic wd);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid       <= 1'b1;
		req.fluid_frac  <= v;
		req.phase_frac  <= c;
		req.want_value  <= wv;
		req.want_derivs <= wd;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		pending_results.push_back(predict_stretch(v, c, wv, wd));
		request_count++;
	endtask

	task automatic end_burst();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// fraction mostly in 0..1, sometimes anything the field holds
	function automatic logic [15:0] rand_fraction();
		case ($urandom_range(9))
			0:       return 16'(32768);
			1:       return 16'd0;
			2:       return 16'($urandom_range(65535));
			default: return 16'($urandom_range(32768));
		endcase
	endfunction

	function automatic logic [15:0] rand_coef();
		case ($urandom_range(7))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'h0000;
			3:       return 16'(-4096);
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	// field extremes, request flags, zero and negative t, saturation
	task automatic test_directed();
		set_coefs(16'd0, 16'd0, 1'b0);
		send_point(16'd0, 16'd0, 1'b1, 1'b1);	// t = 1 exactly
		send_point(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
		send_point(16'd32768, 16'd0, 1'b0, 1'b1);
		send_point(16'd32768, 16'd32768, 1'b0, 1'b0);
		end_burst();
		set_coefs(16'h7FFF, 16'h8000, 1'b0);
		send_point(16'd32768, 16'd32768, 1'b1, 1'b1);
		send_point(16'd32768, 16'd0, 1'b1, 1'b1);	// t negative
		send_point(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);	// 1-c below zero
		send_point(16'h5555, 16'hAAAA, 1'b1, 1'b1);
		end_burst();
		// alpha = -1: t = 0 at v = c = 1, tiny t just below
		set_coefs(16'(-4096), 16'h7FFF, 1'b0);
		send_point(16'd32768, 16'd32768, 1'b1, 1'b1);
		send_point(16'd32767, 16'd32768, 1'b1, 1'b1);
		send_point(16'd1, 16'd32768, 1'b1, 1'b1);
		end_burst();
		set_coefs(16'(-4096), 16'h8000, 1'b1);
		send_point(16'd32768, 16'd32768, 1'b1, 1'b1);
		send_point(16'd32767, 16'd32768, 1'b1, 1'b1);	// inverse saturates
		send_point(16'd100, 16'd32768, 1'b0, 1'b1);
		send_point(16'd0, 16'hFFFF, 1'b1, 1'b0);
		send_point(16'hFFFF, 16'd0, 1'b1, 1'b1);
		end_burst();
		set_coefs(16'h7FFF, 16'h7FFF, 1'b1);
		send_point(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);	// largest t for these coefficients
		send_point(16'd32768, 16'd16384, 1'b1, 1'b1);
		end_burst();
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 50 == 0) begin
				end_burst();
				set_coefs(rand_coef(), rand_coef(), 1'($urandom_range(1)));
			end
			send_point(rand_fraction(), rand_fraction(), 1'($urandom_range(1)),
				1'($urandom_range(1)));
		end
		end_burst();
	endtask

	// result side stalls for a long stretch while requests keep coming
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_coefs(16'd2048, 16'(-1024), 1'b0);
		hold_cycles = 80;
		for (int i = 0; i < 50; i++)
			send_point(rand_fraction(), rand_fraction(), 1'b1, 1'b1);
		end_burst();
	endtask

	initial begin
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		req.valid     = 1'b0;
		req.fluid_frac  = '0;
		req.phase_frac  = '0;
		req.want_value  = 1'b0;
		req.want_derivs = 1'b0;
		alpha_q       = 0;
		domega_q      = 0;
		inverse_q     = 1'b0;
		error_count   = 0;
		result_count  = 0;
		domain_count  = 0;
		request_count = 0;
		hold_cycles   = 0;
		cycle_count   = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		send_idle_pct = 30;
		recv_idle_pct = 47;
		test_random(200);
		send_idle_pct = 47;
		recv_idle_pct = 30;
		test_random(200);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(180);
		test_backpressure();

		$display("run: %0d requests, %0d results, %0d with t <= 0",
			request_count, result_count, domain_count);
		$display("run: both stretch modes, coefficient extremes, random idling, long stall");
		if (error_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/pcsc_pkg.sv
rtl/pcsc_if.sv
rtl/pcsc_newton_step.sv
rtl/phase_change_stretch_cube_root_unit.sv
test/testbench.sv
